>>> sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic task timer table
// Request and result formats, command hand-over record and slot entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int FIRE_CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam int TAG_W      = 8;
  localparam int PERIOD_W   = 24;
  localparam int REM_W      = 25;
  localparam int STEP_W     = 16;
  localparam int SLOT_OUT_W = 4;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [STEP_W-1:0] TICK_STEP_RST = STEP_W'(1);

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic                op;
    logic [TAG_W-1:0]    task_tag;
    logic [PERIOD_W-1:0] period;
    logic                repeat_mode;
  } item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [TAG_W-1:0]      fired_tag;
    logic                  last;
  } result_t;

  // Decoded request handed from the front end to the engine
  typedef struct packed {
    logic                valid;
    logic                is_tick;
    logic [TAG_W-1:0]    task_tag;
    logic [PERIOD_W-1:0] period;
    logic                repeat_mode;
  } cmd_t;

  // One slot of the timer memory; remaining is two's complement
  typedef struct packed {
    logic                repeat_mode;
    logic [PERIOD_W-1:0] reload;
    logic [REM_W-1:0]    remaining;
    logic [TAG_W-1:0]    tag;
  } entry_t;

endpackage

`default_nettype wire

>>> sv/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered and held while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/ptt_front.sv
// ----------------------------------------------------------------------------
// ptt_front: request front end
// Takes requests from the input queue port, decodes add or tick and holds
// them in a short queue until the engine takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire ptt_pkg::item_t item,
  input  wire logic           take,
  output ptt_pkg::cmd_t       cmd
);

  import ptt_pkg::*;

  item_t                q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] cnt;
  logic                 accept;
  logic                 drain;
  item_t                head;

  assign full   = (cnt == CMD_CNT_W'(CMD_DEPTH)) || rst;
  assign accept = push && !full;
  assign drain  = take && (cnt != '0);
  assign head   = q[rd_ptr];

  assign cmd.valid       = (cnt != '0);
  assign cmd.is_tick     = (head.op == OP_TICK);
  assign cmd.task_tag    = head.task_tag;
  assign cmd.period      = head.period;
  assign cmd.repeat_mode = head.repeat_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (drain) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      if (accept && !drain) begin
        cnt <= cnt + CMD_CNT_W'(1);
      end else if (drain && !accept) begin
        cnt <= cnt - CMD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= item;
    end
  end

endmodule

`default_nettype wire

>>> sv/ptt_engine.sv
// ----------------------------------------------------------------------------
// ptt_engine: timer slot engine
// Runs add and tick requests over the slot memory, one slot per cycle unless a
// tick stalls on a full result queue; results go to that queue with the final one marked.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_engine #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ptt_pkg::cmd_t               cmd,
  output logic                             take,
  input  wire logic [ptt_pkg::STEP_W-1:0]  tick_step,
  output logic                             res_push,
  output ptt_pkg::result_t                 res,
  input  wire logic                        res_full
);

  import ptt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADD   = 4'b0010,
    S_TICK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  pv, pv_next;
  logic [IDX_W-1:0]      p_idx, p_idx_next;
  logic [NUM_SLOTS-1:0]  enabled, enabled_next;
  logic [FIRE_CNT_W-1:0] fcnt, fcnt_next;
  logic                  pend_valid, pend_valid_next;
  result_t               pend, pend_next;
  logic [TAG_W-1:0]      cur_tag, cur_tag_next;
  logic [PERIOD_W-1:0]   cur_period, cur_period_next;
  logic                  cur_rep, cur_rep_next;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  entry_t                wr_entry;
  entry_t                rd_entry;
  logic [$bits(entry_t)-1:0] rd_bits;

  logic                  scan_done;
  logic [IDX_W-1:0]      scan_idx;
  logic                  slot_on;
  logic                  expired;
  logic                  fire;
  logic                  report;
  logic                  stall;

  ptt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  assign rd_entry  = entry_t'(rd_bits);
  assign scan_done = (cnt == CNT_W'(NUM_SLOTS));
  assign scan_idx  = cnt[IDX_W-1:0];
  assign slot_on   = pv && enabled[p_idx];
  // Expired when remaining is zero or negative
  assign expired   = rd_entry.remaining[REM_W-1] || (rd_entry.remaining == '0);
  assign fire      = slot_on && expired;
  assign report    = (fcnt < FIRE_CNT_W'(MAX_RESULTS));
  assign stall     = (state == S_TICK) && fire && report && pend_valid && res_full;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pv_next         = pv;
    p_idx_next      = p_idx;
    enabled_next    = enabled;
    fcnt_next       = fcnt;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    cur_tag_next    = cur_tag;
    cur_period_next = cur_period;
    cur_rep_next    = cur_rep;
    take            = 1'b0;
    res_push        = 1'b0;
    res             = pend;
    rd_en           = 1'b0;
    rd_addr         = scan_idx;
    wr_en           = 1'b0;
    wr_addr         = p_idx;
    wr_entry        = rd_entry;

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          take            = 1'b1;
          cur_tag_next    = cmd.task_tag;
          cur_period_next = cmd.period;
          cur_rep_next    = cmd.repeat_mode;
          cnt_next        = '0;
          fcnt_next       = '0;
          pv_next         = 1'b0;
          pend_valid_next = 1'b0;
          state_next      = cmd.is_tick ? S_TICK : S_ADD;
        end
      end

      S_ADD: begin
        if (scan_done) begin
          pend_next.kind      = KIND_FULL;
          pend_next.slot      = '0;
          pend_next.fired_tag = '0;
          pend_next.last      = 1'b1;
          pend_valid_next     = 1'b1;
          state_next          = S_FLUSH;
        end else if (!enabled[scan_idx]) begin
          wr_en                  = 1'b1;
          wr_addr                = scan_idx;
          wr_entry.repeat_mode   = cur_rep;
          wr_entry.reload        = cur_period;
          wr_entry.remaining     = REM_W'(cur_period);
          wr_entry.tag           = cur_tag;
          enabled_next[scan_idx] = 1'b1;
          pend_next.kind         = KIND_ADDED;
          pend_next.slot         = SLOT_OUT_W'(scan_idx);
          pend_next.fired_tag    = cur_tag;
          pend_next.last         = 1'b1;
          pend_valid_next        = 1'b1;
          state_next             = S_FLUSH;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      S_TICK: begin
        if (!stall) begin
          // Issue the read of the next slot while the previous one is updated
          if (!scan_done) begin
            rd_en      = 1'b1;
            cnt_next   = cnt + CNT_W'(1);
            pv_next    = 1'b1;
            p_idx_next = scan_idx;
          end else begin
            pv_next = 1'b0;
          end

          if (fire) begin
            if (report) begin
              // Release the held fire; the newest one stays back for the last mark
              if (pend_valid) begin
                res_push = 1'b1;
                res.last = 1'b0;
              end
              pend_next.kind      = KIND_FIRED;
              pend_next.slot      = SLOT_OUT_W'(p_idx);
              pend_next.fired_tag = rd_entry.tag;
              pend_next.last      = 1'b0;
              pend_valid_next     = 1'b1;
              fcnt_next           = fcnt + FIRE_CNT_W'(1);
            end
            if (rd_entry.repeat_mode) begin
              wr_en              = 1'b1;
              wr_entry.remaining = REM_W'(rd_entry.reload);
            end else begin
              enabled_next[p_idx] = 1'b0;
            end
          end else if (slot_on) begin
            wr_en              = 1'b1;
            wr_entry.remaining = rd_entry.remaining - REM_W'(tick_step);
          end

          if (scan_done && !pv) begin
            state_next = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!res_full) begin
          res_push = 1'b1;
          res.last = 1'b1;
          if (!pend_valid) begin
            res.kind      = KIND_IDLE;
            res.slot      = '0;
            res.fired_tag = '0;
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pv         <= 1'b0;
      enabled    <= '0;
      fcnt       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pv         <= pv_next;
      enabled    <= enabled_next;
      fcnt       <= fcnt_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p_idx      <= p_idx_next;
    pend       <= pend_next;
    cur_tag    <= cur_tag_next;
    cur_period <= cur_period_next;
    cur_rep    <= cur_rep_next;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == S_IDLE) && cmd.valid)
    else $error("request taken while busy or absent");

  a_fire_count_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt <= FIRE_CNT_W'(MAX_RESULTS))
    else $error("fire count beyond the result limit");

  a_last_only_flush: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last) |-> (state == S_FLUSH))
    else $error("final result marked outside the flush step");

  a_stall_holds_scan: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(cnt) && $stable(pv))
    else $error("scan advanced during a stall");

endmodule

`default_nettype wire

>>> sv/ptt_result_queue.sv
// ----------------------------------------------------------------------------
// ptt_result_queue: result output queue
// Short queue between the engine and the result port, oldest result first.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_result_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire ptt_pkg::result_t wr_res,
  output logic                  full,
  output logic                  empty,
  input  wire logic             pop,
  output ptt_pkg::result_t      result
);

  import ptt_pkg::*;

  result_t              q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] cnt;
  logic                 accept;
  logic                 drain;

  assign full   = (cnt == RES_CNT_W'(RES_DEPTH)) || rst;
  assign empty  = (cnt == '0) || rst;
  assign accept = wr && !full;
  assign drain  = pop && !empty;
  assign result = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + RES_PTR_W'(1);
      end
      if (drain) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      if (accept && !drain) begin
        cnt <= cnt + RES_CNT_W'(1);
      end else if (drain && !accept) begin
        cnt <= cnt - RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= wr_res;
    end
  end

endmodule

`default_nettype wire

>>> sv/periodic_task_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table: table of one-shot and periodic timer slots
// Add: the request goes into k, the lowest free slot, or reports the table full.
// Tick: one slot per cycle through the single read port of the slot memory,
// stalling while the result queue is full.
// One request at a time in the engine; two more wait in the front queue.
// Reset clears all enable bits and both queues and sets tick_step to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_table #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire ptt_pkg::item_t             item,
  output logic                            empty,
  input  wire logic                       pop,
  output ptt_pkg::result_t                result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ptt_pkg::STEP_W-1:0] cfg_data
);

  import ptt_pkg::*;

  logic [STEP_W-1:0] tick_step;
  cmd_t              cmd;
  logic              take;
  logic              res_push;
  result_t           res;
  logic              res_full;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      tick_step <= cfg_data;
    end
  end

  ptt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .take (take),
    .cmd  (cmd)
  );

  ptt_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .take      (take),
    .tick_step (tick_step),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  ptt_result_queue u_results (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_push),
    .wr_res (res),
    .full   (res_full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

`default_nettype wire
